FILE: hdl/abd_pkg.sv
// Shared types and constants for the anchor box decode and class argmax block.
package abd_pkg;

	localparam int MAX_CLASSES = 128;
	localparam int GRID_BITS = 8;
	localparam int POS_W = 7;
	localparam int SCORE_W = 16;
	localparam int COORD_W = 19;
	localparam int SIZE_W = 18;
	localparam int CTR_W = GRID_BITS + 17;
	localparam int C35_W = CTR_W + 26;
	localparam int PROD_W = 48;
	localparam int SUM_W = ((C35_W > PROD_W + 2) ? C35_W : PROD_W + 2) + 2;
	localparam int IN_DATA_W = 152;
	localparam int OUT_DATA_W = 168;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [15:0] THRESHOLD_RESET = 16'd16384;
	localparam logic [7:0] NUM_CLASSES_RESET = 8'd80;

	typedef enum logic {
		REG_THRESHOLD = 1'b0,
		REG_NUM_CLASSES = 1'b1
	} reg_sel_t;

	typedef enum logic [2:0] {
		ST_COLLECT,
		ST_SQUARE,
		ST_SCALE,
		ST_SUM,
		ST_LOAD
	} state_t;

	typedef struct packed {
		logic step;
		logic capture;
		logic square;
		logic scale;
		logic sum;
		logic load;
	} dp_cmd_t;

	typedef struct packed {
		logic last;
		logic pass;
	} dp_stat_t;

	typedef struct packed {
		logic [5:0] pad;
		logic [15:0] anchor_h;
		logic [15:0] anchor_w;
		logic [1:0] level;
		logic [7:0] grid_row;
		logic [7:0] grid_col;
		logic [15:0] class_score;
		logic [15:0] objectness;
		logic [15:0] th;
		logic [15:0] tw;
		logic [15:0] ty;
		logic [15:0] tx;
	} in_item_t;

	typedef struct packed {
		logic pad;
		logic [POS_W-1:0] class_index;
		logic [SCORE_W-1:0] best_score;
		logic [SCORE_W-1:0] confidence;
		logic [SCORE_W-1:0] box_objectness;
		logic [SIZE_W-1:0] box_height;
		logic [SIZE_W-1:0] box_width;
		logic [COORD_W-1:0] bottom;
		logic [COORD_W-1:0] right;
		logic [COORD_W-1:0] top;
		logic [COORD_W-1:0] left;
	} out_item_t;

endpackage

FILE: hdl/anchor_box_decode_argmax.sv
// Top level of the anchor box decode and class argmax block with its register port.
//
// Each grid cell arrives as num_classes requests, one class score per request and one
// request per cycle while no box is being decoded; the block keeps the first highest
// score and its index. On the cell's last request, if objectness reaches the threshold,
// the box is decoded from that request's terms through four steps (square, scale, edge
// sums, saturate and load) in which no request is taken; the load step also waits
// while the result register still holds a result that has not been taken.
// Cells below the threshold produce nothing.
module anchor_box_decode_argmax
	import abd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// tx, ty, tw, th, objectness, class_score, grid_col, grid_row, level,
	// anchor_w, anchor_h, then zero fill.
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// left, top, right, bottom, box_width, box_height, box_objectness,
	// confidence, best_score, class_index, then zero fill.
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic [15:0] threshold_q;
	logic [7:0] num_classes_q;
	reg_sel_t reg_sel;
	logic cfg_write;
	dp_cmd_t cmd;
	dp_stat_t stat;
	in_item_t item;
	out_item_t result;

	assign pready = 1'b1;
	assign reg_sel = reg_sel_t'(paddr[2]);
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
			num_classes_q <= NUM_CLASSES_RESET;
		end else if (cfg_write) begin
			case (reg_sel)
				REG_THRESHOLD: begin
					threshold_q <= pwdata[15:0];
				end
				REG_NUM_CLASSES: begin
					num_classes_q <= pwdata[7:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_THRESHOLD: begin
				prdata = CFG_DATA_W'(threshold_q);
			end
			REG_NUM_CLASSES: begin
				prdata = CFG_DATA_W'(num_classes_q);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	assign item = s_tdata;
	assign m_tdata = result;

	abd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	abd_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.item        (item),
		.threshold   (threshold_q),
		.num_classes (num_classes_q),
		.result      (result)
	);

endmodule

FILE: hdl/abd_ctrl.sv
// Controller state machine that sequences the argmax update and the box decode steps.
module abd_ctrl
	import abd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	output logic     m_tvalid,
	input  logic     m_tready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t state_q;
	state_t state_d;
	logic m_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_COLLECT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		s_tready = (state_q == ST_COLLECT);
		case (state_q)
			ST_COLLECT: begin
				if (s_tvalid) begin
					cmd.step = 1'b1;
					if (stat.last && stat.pass) begin
						cmd.capture = 1'b1;
						state_d = ST_SQUARE;
					end
				end
			end
			ST_SQUARE: begin
				cmd.square = 1'b1;
				state_d = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				if (!m_valid_q || m_tready) begin
					cmd.load = 1'b1;
					state_d = ST_COLLECT;
				end
			end
			default: begin
				state_d = ST_COLLECT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_valid_q;

`ifndef SYNTHESIS
	a_valid_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> $past(state_q == ST_LOAD))
		else $error("result became valid without a load");

	a_decode_from_request: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SQUARE) |-> $past(s_tvalid && (state_q == ST_COLLECT)))
		else $error("decode started without an accepted request");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD && m_valid_q && !m_tready) |=> (state_q == ST_LOAD))
		else $error("pending result would be overwritten");
`endif

endmodule

FILE: hdl/abd_datapath.sv
// Datapath with the running class argmax, the box decode arithmetic and the result register.
module abd_datapath
	import abd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_stat_t    stat,
	input  in_item_t    item,
	input  logic [15:0] threshold,
	input  logic [7:0]  num_classes,
	output out_item_t   result
);

	localparam logic [CTR_W-1:0] HALF_Q15 = CTR_W'(16384);
	localparam logic [SUM_W-1:0] ROUND_BIAS = SUM_W'(64'd1 << 30);
	localparam logic [PROD_W:0] SIZE_BIAS = (PROD_W + 1)'(64'd1 << 28);
	localparam logic signed [SUM_W-32:0] Q_MAX = (SUM_W - 31)'(262143);
	localparam logic signed [SUM_W-32:0] Q_MIN = (SUM_W - 31)'(-262144);
	localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(262143);
	localparam logic [COORD_W-1:0] COORD_MIN = COORD_W'(-262144);
	localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

	function automatic logic [POS_W:0] clamp_classes(input logic [7:0] v);
		if (v == 8'd0) begin
			return (POS_W + 1)'(1);
		end else if (int'(v) > MAX_CLASSES) begin
			return (POS_W + 1)'(MAX_CLASSES);
		end
		return v[POS_W:0];
	endfunction

	function automatic logic [COORD_W-1:0] sat_coord(input logic [SUM_W-1:0] s);
		logic signed [SUM_W-32:0] q;
		q = s[SUM_W-1:31];
		if (q > Q_MAX) begin
			return COORD_MAX;
		end else if (q < Q_MIN) begin
			return COORD_MIN;
		end
		return q[COORD_W-1:0];
	endfunction

	logic [POS_W-1:0] pos_q;
	logic [SCORE_W-1:0] best_q;
	logic [POS_W-1:0] best_idx_q;
	logic [SCORE_W-1:0] best_d;
	logic [POS_W-1:0] best_idx_d;
	logic [POS_W:0] class_count;
	logic last;

	logic [15:0] tx_q, ty_q, tw_q, th_q, obj_q, aw_q, ah_q;
	logic [GRID_BITS-1:0] gcol_q, grow_q;
	logic [1:0] level_q;

	logic [31:0] sqw_s1, sqh_s1, conf_prod_s1;
	logic [CTR_W-1:0] cx15_s1, cy15_s1;

	logic [PROD_W-1:0] w_s2, h_s2;
	logic signed [C35_W-1:0] cx35_s2, cy35_s2;
	logic [SCORE_W-1:0] conf_s2;
	logic [32:0] conf_round;
	logic [17:0] conf_shift;
	logic [4:0] shift_amt;

	logic [SUM_W-1:0] lsum_s3, rsum_s3, tsum_s3, bsum_s3;
	logic [PROD_W-PROD_W+19:0] wq_s3, hq_s3;
	logic [PROD_W:0] w_round, h_round;
	logic [SUM_W-1:0] cx_ext, cy_ext, half_w, half_h;

	out_item_t res_q;

	always_comb begin
		class_count = clamp_classes(num_classes);
		best_d = best_q;
		best_idx_d = best_idx_q;
		if (pos_q == '0) begin
			best_d = item.class_score;
			best_idx_d = '0;
		end else if (item.class_score > best_q) begin
			best_d = item.class_score;
			best_idx_d = pos_q;
		end
		last = (({1'b0, pos_q} + (POS_W + 1)'(1)) >= class_count);
		stat.last = last;
		stat.pass = (item.objectness >= threshold);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			best_q <= '0;
			best_idx_q <= '0;
		end else if (cmd.step) begin
			best_q <= best_d;
			best_idx_q <= best_idx_d;
			pos_q <= last ? '0 : pos_q + POS_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			tx_q <= item.tx;
			ty_q <= item.ty;
			tw_q <= item.tw;
			th_q <= item.th;
			obj_q <= item.objectness;
			aw_q <= item.anchor_w;
			ah_q <= item.anchor_h;
			gcol_q <= GRID_BITS'(item.grid_col);
			grow_q <= GRID_BITS'(item.grid_row);
			level_q <= item.level;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.square) begin
			sqw_s1 <= 32'(tw_q) * 32'(tw_q);
			sqh_s1 <= 32'(th_q) * 32'(th_q);
			conf_prod_s1 <= 32'(obj_q) * 32'(best_q);
			cx15_s1 <= CTR_W'({gcol_q, 15'd0}) + CTR_W'({tx_q, 1'b0}) - HALF_Q15;
			cy15_s1 <= CTR_W'({grow_q, 15'd0}) + CTR_W'({ty_q, 1'b0}) - HALF_Q15;
		end
	end

	always_comb begin
		shift_amt = 5'd23 + 5'(level_q);
		conf_round = 33'(conf_prod_s1) + 33'd16384;
		conf_shift = conf_round[32:15];
	end

	always_ff @(posedge clk) begin
		if (cmd.scale) begin
			w_s2 <= PROD_W'(sqw_s1) * PROD_W'(aw_q);
			h_s2 <= PROD_W'(sqh_s1) * PROD_W'(ah_q);
			cx35_s2 <= C35_W'($signed(cx15_s1)) <<< shift_amt;
			cy35_s2 <= C35_W'($signed(cy15_s1)) <<< shift_amt;
			conf_s2 <= (conf_shift > 18'd65535) ? '1 : conf_shift[SCORE_W-1:0];
		end
	end

	always_comb begin
		cx_ext = SUM_W'(cx35_s2);
		cy_ext = SUM_W'(cy35_s2);
		half_w = SUM_W'({w_s2, 1'b0});
		half_h = SUM_W'({h_s2, 1'b0});
		w_round = (PROD_W + 1)'(w_s2) + SIZE_BIAS;
		h_round = (PROD_W + 1)'(h_s2) + SIZE_BIAS;
	end

	always_ff @(posedge clk) begin
		if (cmd.sum) begin
			lsum_s3 <= cx_ext - half_w + ROUND_BIAS;
			rsum_s3 <= cx_ext + half_w + ROUND_BIAS;
			tsum_s3 <= cy_ext - half_h + ROUND_BIAS;
			bsum_s3 <= cy_ext + half_h + ROUND_BIAS;
			wq_s3 <= w_round[PROD_W:29];
			hq_s3 <= h_round[PROD_W:29];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_q.pad <= 1'b0;
			res_q.left <= sat_coord(lsum_s3);
			res_q.right <= sat_coord(rsum_s3);
			res_q.top <= sat_coord(tsum_s3);
			res_q.bottom <= sat_coord(bsum_s3);
			res_q.box_width <= (wq_s3 > 20'(SIZE_MAX)) ? SIZE_MAX : wq_s3[SIZE_W-1:0];
			res_q.box_height <= (hq_s3 > 20'(SIZE_MAX)) ? SIZE_MAX : hq_s3[SIZE_W-1:0];
			res_q.box_objectness <= obj_q;
			res_q.confidence <= conf_s2;
			res_q.best_score <= best_q;
			res_q.class_index <= best_idx_q;
		end
	end

	assign result = res_q;

`ifndef SYNTHESIS
	a_left_le_right: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> ($signed(res_q.left) <= $signed(res_q.right)))
		else $error("decoded left edge lies right of the right edge");

	a_top_le_bottom: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> ($signed(res_q.top) <= $signed(res_q.bottom)))
		else $error("decoded top edge lies below the bottom edge");

	a_best_never_drops: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && (pos_q != '0)) |=> (best_q >= $past(best_q)))
		else $error("running best score dropped within a cell");
`endif

endmodule
